[rtl/core/cmmstr_pkg.sv]
// shared types and constants for the clamp and min-max stretch core
package cmmstr_pkg;

	localparam int NUM_CH = 3;

	typedef logic [1:0] ch_idx_t;

	localparam ch_idx_t CH_BLUE  = 2'd0;
	localparam ch_idx_t CH_GREEN = 2'd1;
	localparam ch_idx_t CH_RED   = 2'd2;

	typedef enum logic [2:0] {
		REG_LOW_BLUE   = 3'd0,
		REG_LOW_GREEN  = 3'd1,
		REG_LOW_RED    = 3'd2,
		REG_HIGH_BLUE  = 3'd3,
		REG_HIGH_GREEN = 3'd4,
		REG_HIGH_RED   = 3'd5,
		REG_OUT_MIN    = 3'd6,
		REG_OUT_MAX    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic    accept;
		logic    gather;
		logic    mul;
		logic    sum;
		logic    step;
		logic    round;
		logic    load_out;
		ch_idx_t ch;
	} dp_cmd_t;

	typedef struct packed {
		logic skip;
	} dp_status_t;

endpackage

[rtl/core/cmmstr_ctrl.sv]
// controller state machine: sequences multiply, sum, divide and round per channel
module cmmstr_ctrl #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  cmmstr_pkg::dp_status_t status,
	output cmmstr_pkg::dp_cmd_t    cmd
);

	localparam int DIV_STEPS = 2 * PIXEL_BITS + 1;
	localparam int CW = $clog2(DIV_STEPS);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_MUL   = 6'b000010,
		ST_SUM   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_ROUND = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	cmmstr_pkg::ch_idx_t ch_q, ch_d;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ch_d         = ch_q;
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.accept   = accept;
		cmd.gather   = accept && !command;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command) begin
					state_d = ST_MUL;
					ch_d    = cmmstr_pkg::CH_BLUE;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (status.skip) begin
					state_d = ST_ROUND;
				end else begin
					state_d = ST_DIV;
					cnt_d   = CW'(DIV_STEPS - 1);
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_ROUND;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (ch_q == cmmstr_pkg::CH_RED) begin
					state_d = ST_OUT;
				end else begin
					ch_d    = ch_q + 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			ch_q        <= cmmstr_pkg::CH_BLUE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			ch_q        <= ch_d;
			out_valid_q <= cmd.load_out || (out_valid_q && out_stall);
		end
	end

endmodule

[rtl/core/cmmstr_dp.sv]
// datapath: config registers, clamp, statistics, stretch arithmetic and output word
module cmmstr_dp #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [PIXEL_BITS-1:0]  cfg_data,
	input  logic                   frame_start,
	input  logic [PIXEL_BITS-1:0]  blue_in,
	input  logic [PIXEL_BITS-1:0]  green_in,
	input  logic [PIXEL_BITS-1:0]  red_in,
	output logic [PIXEL_BITS-1:0]  blue_out,
	output logic [PIXEL_BITS-1:0]  green_out,
	output logic [PIXEL_BITS-1:0]  red_out,
	input  cmmstr_pkg::dp_cmd_t    cmd,
	output cmmstr_pkg::dp_status_t status
);

	localparam int P   = PIXEL_BITS;
	localparam int W   = 2 * P + 1;
	localparam int TW  = 2 * P + 2;
	localparam int NCH = cmmstr_pkg::NUM_CH;

	logic [P-1:0] low_q [NCH];
	logic [P-1:0] high_q [NCH];
	logic [P-1:0] omin_q, omax_q;
	logic [P-1:0] min_q [NCH];
	logic [P-1:0] max_q [NCH];
	logic [P-1:0] pix_q [NCH];
	logic [P-1:0] res_q [NCH];
	logic [P-1:0] in_pix [NCH];
	logic [P-1:0] clamp_v [NCH];
	logic [P-1:0] high_v [NCH];

	logic [P-1:0]         sel_pix, sel_min, sel_max, den;
	logic signed [P:0]    diff_c, diff_o;
	logic [2*P-1:0]       p1_s1;
	logic signed [TW-1:0] p2_s1;
	logic [P-1:0]         den_s1;
	logic                 flat_s1;
	logic signed [TW-1:0] t_sum;
	logic                 neg_q;
	logic [P-1:0]         rem_q;
	logic [W-1:0]         quo_q;
	logic [P:0]           shifted;
	logic                 ge;
	logic [P:0]           trial;
	logic [P:0]           r2;
	logic                 up;
	logic [W:0]           qr;
	logic                 sat;
	logic [P-1:0]         res_v;
	logic [P-1:0]         out_b_q, out_g_q, out_r_q;

	assign in_pix[0] = blue_in;
	assign in_pix[1] = green_in;
	assign in_pix[2] = red_in;

	// clamp to high limit, then raise to low limit
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			high_v[i]  = (in_pix[i] > high_q[i]) ? high_q[i] : in_pix[i];
			clamp_v[i] = (high_v[i] <= low_q[i]) ? low_q[i] : high_v[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				low_q[i]  <= '0;
				high_q[i] <= '1;
			end
			omin_q <= '0;
			omax_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmmstr_pkg::REG_LOW_BLUE:   low_q[0]  <= cfg_data;
				cmmstr_pkg::REG_LOW_GREEN:  low_q[1]  <= cfg_data;
				cmmstr_pkg::REG_LOW_RED:    low_q[2]  <= cfg_data;
				cmmstr_pkg::REG_HIGH_BLUE:  high_q[0] <= cfg_data;
				cmmstr_pkg::REG_HIGH_GREEN: high_q[1] <= cfg_data;
				cmmstr_pkg::REG_HIGH_RED:   high_q[2] <= cfg_data;
				cmmstr_pkg::REG_OUT_MIN:    omin_q    <= cfg_data;
				cmmstr_pkg::REG_OUT_MAX:    omax_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if (cmd.gather) begin
			for (int i = 0; i < NCH; i++) begin
				if (frame_start || (clamp_v[i] < min_q[i])) begin
					min_q[i] <= clamp_v[i];
				end
				if (frame_start || (clamp_v[i] > max_q[i])) begin
					max_q[i] <= clamp_v[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < NCH; i++) begin
				pix_q[i] <= clamp_v[i];
			end
		end
	end

	// products for the selected channel
	assign sel_pix = pix_q[cmd.ch];
	assign sel_min = min_q[cmd.ch];
	assign sel_max = max_q[cmd.ch];
	assign den     = sel_max - sel_min;
	assign diff_c  = $signed({1'b0, sel_pix}) - $signed({1'b0, sel_min});
	assign diff_o  = $signed({1'b0, omax_q}) - $signed({1'b0, omin_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p1_s1   <= {{P{1'b0}}, omin_q} * {{P{1'b0}}, den};
			p2_s1   <= TW'(diff_c) * TW'(diff_o);
			den_s1  <= den;
			flat_s1 <= (sel_max <= sel_min);
		end
	end

	assign t_sum       = $signed({2'b00, p1_s1}) + p2_s1;
	assign status.skip = flat_s1 || t_sum[TW-1];

	// restoring divider, one quotient bit per step
	assign shifted = {rem_q, quo_q[W-1]};
	assign ge      = (shifted >= {1'b0, den_s1});
	assign trial   = shifted - {1'b0, den_s1};

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			neg_q <= t_sum[TW-1];
			rem_q <= '0;
			quo_q <= t_sum[W-1:0];
		end else if (cmd.step) begin
			rem_q <= ge ? trial[P-1:0] : shifted[P-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	// round half to even, then saturate; a flat range gives the output minimum and a negative numerator gives zero
	assign r2  = {rem_q, 1'b0};
	assign up  = (r2 > {1'b0, den_s1}) || ((r2 == {1'b0, den_s1}) && quo_q[0]);
	assign qr  = {1'b0, quo_q} + {{W{1'b0}}, up};
	assign sat = (qr[W:P] != '0);

	always_comb begin
		if (flat_s1) begin
			res_v = omin_q;
		end else if (neg_q) begin
			res_v = '0;
		end else if (sat) begin
			res_v = '1;
		end else begin
			res_v = qr[P-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			res_q[cmd.ch] <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_b_q <= res_q[0];
			out_g_q <= res_q[1];
			out_r_q <= res_q[2];
		end
	end

	assign blue_out  = out_b_q;
	assign green_out = out_g_q;
	assign red_out   = out_r_q;

endmodule

[rtl/core/clamp_and_minmax_stretch_rgb_core.sv]
// top level of the clamp and min-max stretch core for bgr pixels
//
//  port group  direction  handshake             word
//  input       in         in_valid / in_stall   command, frame_start, blue_in, green_in, red_in
//  output      out        out_valid / out_stall blue_out, green_out, red_out
//  config      in         cfg_we                cfg_index, cfg_data
//
// a gather word is taken while idle and leaves the core idle, ready for the next word
// a map word takes each channel in turn through multiply, sum, divide and round; it uses the
// shared restoring divider that yields one quotient bit per cycle for each channel
// a flat range or a negative numerator skips the divider for that channel
// the finished word sits in an output register, so a stalled output holds only the
// final load; reset clears control state and statistics, no clearing pass
module clamp_and_minmax_stretch_rgb_core #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [PIXEL_BITS-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic                  frame_start,
	input  logic [PIXEL_BITS-1:0] blue_in,
	input  logic [PIXEL_BITS-1:0] green_in,
	input  logic [PIXEL_BITS-1:0] red_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIXEL_BITS-1:0] blue_out,
	output logic [PIXEL_BITS-1:0] green_out,
	output logic [PIXEL_BITS-1:0] red_out
);

	cmmstr_pkg::dp_cmd_t    cmd;
	cmmstr_pkg::dp_status_t status;

	cmmstr_ctrl #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cmmstr_dp #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.frame_start(frame_start),
		.blue_in    (blue_in),
		.green_in   (green_in),
		.red_in     (red_in),
		.blue_out   (blue_out),
		.green_out  (green_out),
		.red_out    (red_out),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
